// ===== rtl/core/mmn_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmn_pkg
// Shared widths, defaults and controller/datapath handshake types for the
// min-max normalizer.
// ---------------------------------------------------------------------------
package mmn_pkg;

  // defaults for the top-level parameters
  localparam int unsigned SampleWidthDef  = 32;
  localparam int unsigned FractionBitsDef = 16;

  // fixed payload widths of the channels
  localparam int unsigned SampleW = 32;
  localparam int unsigned NormW   = 16;
  localparam int unsigned RangeW  = 32;

  // reciprocal low word split for the partial products
  localparam int unsigned RecipLoW = 32;

  typedef struct packed {
    logic capture;
    logic meas_update;
    logic div_start;
    logic scale_diff;
    logic scale_lo;
    logic scale_hi;
    logic scale_sum;
    logic load_out;
  } mmn_cmd_t;

  typedef struct packed {
    logic in_scale;
    logic is_last;
    logic span_pos;
    logic div_done;
  } mmn_status_t;

endpackage

// ===== rtl/core/mmn_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmn_in_if
// Input sample channel: valid/ready handshake with one sample beat.
// ---------------------------------------------------------------------------
interface mmn_in_if;
  import mmn_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [SampleW-1:0] sample;
  logic                      last;

  modport source (output valid, output req_type, output sample, output last, input ready);
  modport sink   (input valid, input req_type, input sample, input last, output ready);

endinterface

// ===== rtl/core/mmn_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmn_out_if
// Result channel: valid/ready handshake with one result beat.
// ---------------------------------------------------------------------------
interface mmn_out_if;
  import mmn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [NormW-1:0]         normalized;
  logic                     not_scaled;
  logic signed [RangeW-1:0] range_min;
  logic signed [RangeW-1:0] range_max;

  modport source (output valid, output normalized, output not_scaled,
                  output range_min, output range_max, input ready);
  modport sink   (input valid, input normalized, input not_scaled,
                  input range_min, input range_max, output ready);

endinterface

// ===== rtl/core/min_max_normalizer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min_max_normalizer
// Two-pass min-max normalizer: measure pass tracks the range, scale pass
// maps each sample to an unsigned fraction of that range.
// ---------------------------------------------------------------------------
// One beat is taken at a time and each gives one result beat. A measure beat
// runs through capture, range update and result load; a scale beat runs through
// capture, difference, low and high partial products of the (33 + FRACTION_BITS)-bit
// reciprocal, sum and clamp, and result load. The last beat of a measure pass with
// a non-empty range also runs the restoring divider that forms
// floor(2^(32+FRACTION_BITS) / (max - min)), one quotient bit per cycle. The
// result register holds a finished beat while the block goes back to idle,
// so the next beat is accepted while a result still waits downstream.
// ---------------------------------------------------------------------------
module min_max_normalizer #(
  parameter int unsigned SAMPLE_WIDTH  = mmn_pkg::SampleWidthDef,
  parameter int unsigned FRACTION_BITS = mmn_pkg::FractionBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmn_in_if.sink    in_i,
  mmn_out_if.source out_o
);
  import mmn_pkg::*;

  mmn_cmd_t    cmd;
  mmn_status_t status;

  mmn_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmn_datapath #(
    .SampleWidth  (SAMPLE_WIDTH),
    .FractionBits (FRACTION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (in_i.req_type),
    .sample_i     (in_i.sample),
    .last_i       (in_i.last),
    .normalized_o (out_o.normalized),
    .not_scaled_o (out_o.not_scaled),
    .range_min_o  (out_o.range_min),
    .range_max_o  (out_o.range_max)
  );

endmodule

// ===== rtl/core/mmn_divider.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmn_divider
// Restoring divider, one quotient bit per cycle, for the range reciprocal.
// ---------------------------------------------------------------------------
module mmn_divider #(
  parameter int unsigned DividendW = 49,
  parameter int unsigned DivisorW  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW:0]    trial;
  logic                 fits;

  // dividend bits shift out of the top of quo_q as quotient bits shift in
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendW);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DivisorW'(trial - {1'b0, dvs_q}) : trial[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = busy_q && (cnt_q == CntW'(1));
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/mmn_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmn_datapath
// Range tracking, reciprocal, split multiply and clamping of one sample.
// ---------------------------------------------------------------------------
module mmn_datapath #(
  parameter int unsigned SampleWidth  = 32,
  parameter int unsigned FractionBits = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mmn_pkg::mmn_cmd_t                 cmd_i,
  output mmn_pkg::mmn_status_t              status_o,
  input  logic                              req_type_i,
  input  logic signed [mmn_pkg::SampleW-1:0] sample_i,
  input  logic                              last_i,
  output logic [mmn_pkg::NormW-1:0]         normalized_o,
  output logic                              not_scaled_o,
  output logic signed [mmn_pkg::RangeW-1:0] range_min_o,
  output logic signed [mmn_pkg::RangeW-1:0] range_max_o
);
  import mmn_pkg::*;

  localparam int unsigned SW  = SampleWidth;
  localparam int unsigned FB  = FractionBits;
  localparam int unsigned RW  = 33 + FractionBits;
  localparam int unsigned HW  = RW - RecipLoW;
  localparam int unsigned LoW = SW + RecipLoW;
  localparam int unsigned HiW = SW + HW;

  localparam logic signed [SW-1:0] SmpMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SmpMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic [RW-1:0]        RecipNum = {1'b1, {(RW-1){1'b0}}};

  logic                 last_q;
  logic signed [SW-1:0] smp_q;
  logic signed [SW-1:0] low_q, high_q, fin_low_q, fin_high_q;
  logic [SW-1:0]        span_q;
  logic                 degen_q;
  logic signed [SW:0]   diff_q;
  logic                 clamp_lo_q, clamp_hi_q;
  logic [LoW-1:0]       prod_lo_q;
  logic [HiW-1:0]       prod_hi_q;
  logic [FB-1:0]        res_norm_q;
  logic signed [SW-1:0] res_min_q, res_max_q;

  logic signed [SW-1:0] low_new, high_new;
  logic signed [SW:0]   span_w;
  logic                 span_pos;
  logic                 div_done;
  logic [RW-1:0]        recip;
  logic [HiW:0]         total;
  logic                 sat;
  logic [FB-1:0]        norm_w;
  logic [FB+NormW-1:0]  norm_ext;

  mmn_divider #(
    .DividendW (RW),
    .DivisorW  (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (RecipNum),
    .divisor_i  (span_w[SW-1:0]),
    .done_o     (div_done),
    .quotient_o (recip)
  );

  assign low_new  = (smp_q < low_q)  ? smp_q : low_q;
  assign high_new = (smp_q > high_q) ? smp_q : high_q;
  assign span_w   = (SW+1)'(high_new) - (SW+1)'(low_new);
  assign span_pos = !span_w[SW] && (span_w != '0);

  // product >> 32 is the high partial product plus the carry word of the low one
  assign total = (HiW+1)'(prod_hi_q) + (HiW+1)'(prod_lo_q[LoW-1:RecipLoW]);
  assign sat   = |total[HiW:FB];

  always_comb begin
    if (degen_q || clamp_lo_q) begin
      norm_w = '0;
    end else if (clamp_hi_q || sat) begin
      norm_w = '1;
    end else begin
      norm_w = total[FB-1:0];
    end
  end

  assign norm_ext = {{NormW{1'b0}}, res_norm_q};

  assign status_o.in_scale = req_type_i;
  assign status_o.is_last  = last_q;
  assign status_o.span_pos = span_pos;
  assign status_o.div_done = div_done;

  // range state carries reset values of its own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= SmpMax;
      high_q     <= SmpMin;
      fin_low_q  <= '0;
      fin_high_q <= '0;
      span_q     <= '0;
      degen_q    <= 1'b1;
    end else if (cmd_i.meas_update) begin
      if (last_q) begin
        fin_low_q  <= low_new;
        fin_high_q <= high_new;
        span_q     <= span_w[SW-1:0];
        degen_q    <= !span_pos;
        low_q      <= SmpMax;
        high_q     <= SmpMin;
      end else begin
        low_q  <= low_new;
        high_q <= high_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      last_q <= last_i & ~req_type_i;
      smp_q  <= sample_i[SW-1:0];
    end
    if (cmd_i.meas_update) begin
      res_norm_q <= '0;
      res_min_q  <= low_new;
      res_max_q  <= high_new;
    end
    if (cmd_i.scale_diff) begin
      diff_q <= (SW+1)'(smp_q) - (SW+1)'(fin_low_q);
    end
    if (cmd_i.scale_lo) begin
      prod_lo_q  <= LoW'(diff_q[SW-1:0]) * LoW'(recip[RecipLoW-1:0]);
      clamp_lo_q <= diff_q[SW];
      clamp_hi_q <= !diff_q[SW] && (diff_q[SW-1:0] > span_q);
    end
    if (cmd_i.scale_hi) begin
      prod_hi_q <= HiW'(diff_q[SW-1:0]) * HiW'(recip[RW-1:RecipLoW]);
    end
    if (cmd_i.scale_sum) begin
      res_norm_q <= norm_w;
      res_min_q  <= fin_low_q;
      res_max_q  <= fin_high_q;
    end
    if (cmd_i.load_out) begin
      normalized_o <= norm_ext[NormW-1:0];
      not_scaled_o <= degen_q;
      range_min_o  <= RangeW'(res_min_q);
      range_max_o  <= RangeW'(res_max_q);
    end
  end

endmodule

// ===== rtl/core/mmn_controller.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmn_controller
// Sequencer for measure and scale beats, and the result register valid.
// ---------------------------------------------------------------------------
module mmn_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mmn_pkg::mmn_status_t status_i,
  output mmn_pkg::mmn_cmd_t    cmd_o
);
  import mmn_pkg::*;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StMeas   = 8'b0000_0010,
    StDiv    = 8'b0000_0100,
    StDiff   = 8'b0000_1000,
    StMulLo  = 8'b0001_0000,
    StMulHi  = 8'b0010_0000,
    StSum    = 8'b0100_0000,
    StEmit   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.in_scale ? StDiff : StMeas;
        end
      end
      StMeas: begin
        cmd_o.meas_update = 1'b1;
        if (status_i.is_last && status_i.span_pos) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StEmit;
        end
      end
      StDiv: begin
        if (status_i.div_done) begin
          state_d = StEmit;
        end
      end
      StDiff: begin
        cmd_o.scale_diff = 1'b1;
        state_d = StMulLo;
      end
      StMulLo: begin
        cmd_o.scale_lo = 1'b1;
        state_d = StMulHi;
      end
      StMulHi: begin
        cmd_o.scale_hi = 1'b1;
        state_d = StSum;
      end
      StSum: begin
        cmd_o.scale_sum = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        // hold the finished beat until the result register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
